@@ hw/rtl/lzd_pkg.sv @@
// Package with the types and constants shared by the LZ77 decompressor.
`default_nettype none

package lzd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SIZE0  = 3'd1,
        PH_SIZE1  = 3'd2,
        PH_SIZE2  = 3'd3,
        PH_FLAGS  = 3'd4,
        PH_TOKEN  = 3'd5,
        PH_MATCH  = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_COPY = 1'b1
    } t_state;

    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned DISP_W   = 13;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned TOKEN_W  = 4;

    localparam logic [CNT_W-1:0]   LEN_BIAS        = CNT_W'(3);
    localparam logic [DISP_W-1:0]  DISP_BIAS       = DISP_W'(1);
    localparam logic [TOKEN_W-1:0] TOKENS_PER_FLAG = TOKEN_W'(8);

endpackage

`default_nettype wire

@@ hw/rtl/lz77_decompress_top.sv @@
// LZ77 type 10 stream decompressor with a history window and a byte-wide output register.
// A literal byte appears at the output register in the cycle after its input transfer.
// A match token copies one byte per cycle while the output register is free (up to 18),
// with one window read and one window write per copied byte.
// Reset is synchronous and active low and clears the parser and the output valid flag.
// The window is never swept: reads behind the running output count return zero.
`default_nettype none

module lz77_decompress_top #(
    parameter int unsigned WINDOW_DEPTH = 4096
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_stream_start,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_stream_done
);
    import lzd_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);

    logic [7:0] r_window [WINDOW_DEPTH];

    t_state              r_state,  n_state;
    t_phase              r_phase,  n_phase;
    logic [SIZE_W-1:0]   r_total,  n_total;
    logic [SIZE_W-1:0]   r_wc,     n_wc;
    logic [7:0]          r_flags,  n_flags;
    logic [TOKEN_W-1:0]  r_tokens, n_tokens;
    logic [7:0]          r_high,   n_high;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic [DISP_W-1:0]   r_disp,   n_disp;
    logic [AW-1:0]       r_wp,     n_wp;
    logic [AW-1:0]       r_rp,     n_rp;
    logic [7:0]          r_prev,   n_prev;
    logic [7:0]          r_rd_data;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte,  n_out_byte;
    logic                r_out_last,  n_out_last;
    logic                r_out_done,  n_out_done;

    logic                in_fire;
    logic                slot_free;
    t_phase              cur_phase;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                emit;
    logic [7:0]          emit_byte;
    logic                emit_last;
    logic                emit_done;
    logic                tok_end;
    logic [SIZE_W-1:0]   wc_inc;
    logic [DISP_W-1:0]   new_disp;
    logic [AW:0]         back_diff;
    logic [AW-1:0]       first_addr;
    logic [7:0]          copy_byte;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && slot_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign cur_phase  = i_stream_start ? PH_HEADER : r_phase;
    assign wc_inc     = r_wc + SIZE_W'(1);

    assign new_disp   = {1'b0, r_high[3:0], i_in_byte} + DISP_BIAS;
    assign back_diff  = {1'b0, r_wp} - (AW+1)'(new_disp);
    assign first_addr = back_diff[AW] ? AW'(back_diff + (AW+1)'(WINDOW_DEPTH))
                                      : back_diff[AW-1:0];

    always_comb begin
        if (r_wc < SIZE_W'(r_disp)) begin
            copy_byte = 8'd0;
        end else if (r_disp == DISP_BIAS) begin
            copy_byte = r_prev;
        end else begin
            copy_byte = r_rd_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_total     = r_total;
        n_wc        = r_wc;
        n_flags     = r_flags;
        n_tokens    = r_tokens;
        n_high      = r_high;
        n_cnt       = r_cnt;
        n_disp      = r_disp;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_prev      = r_prev;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        rd_en       = 1'b0;
        rd_addr     = r_rp;
        emit        = 1'b0;
        emit_byte   = i_in_byte;
        emit_last   = 1'b0;
        emit_done   = 1'b0;
        tok_end     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_stream_start) begin
                        n_total  = '0;
                        n_wc     = '0;
                        n_wp     = '0;
                        n_flags  = '0;
                        n_tokens = '0;
                        n_high   = '0;
                    end
                    case (cur_phase)
                        PH_HEADER: begin
                            n_phase = PH_SIZE0;
                        end
                        PH_SIZE0: begin
                            n_total = {16'd0, i_in_byte};
                            n_phase = PH_SIZE1;
                        end
                        PH_SIZE1: begin
                            n_total = {r_total[23:16], i_in_byte, r_total[7:0]};
                            n_phase = PH_SIZE2;
                        end
                        PH_SIZE2: begin
                            n_total = {i_in_byte, r_total[15:0]};
                            n_phase = ({i_in_byte, r_total[15:0]} == '0) ? PH_DONE
                                                                          : PH_FLAGS;
                        end
                        PH_FLAGS: begin
                            n_flags  = i_in_byte;
                            n_tokens = TOKENS_PER_FLAG;
                            n_phase  = PH_TOKEN;
                        end
                        PH_TOKEN: begin
                            if (r_flags[7]) begin
                                n_high  = i_in_byte;
                                n_phase = PH_MATCH;
                            end else begin
                                emit      = 1'b1;
                                emit_byte = i_in_byte;
                                emit_last = 1'b1;
                                emit_done = (wc_inc == r_total);
                                tok_end   = 1'b1;
                            end
                        end
                        PH_MATCH: begin
                            n_disp  = new_disp;
                            n_cnt   = CNT_W'(r_high[7:4]) + LEN_BIAS;
                            rd_en   = 1'b1;
                            rd_addr = first_addr;
                            n_rp    = ptr_inc(first_addr);
                            n_state = ST_COPY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COPY: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_byte = copy_byte;
                    emit_done = (wc_inc == r_total);
                    emit_last = (r_cnt == CNT_W'(1)) || emit_done;
                    n_cnt     = r_cnt - CNT_W'(1);
                    rd_en     = 1'b1;
                    rd_addr   = r_rp;
                    n_rp      = ptr_inc(r_rp);
                    if (emit_last) begin
                        tok_end = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (tok_end) begin
            n_flags  = {r_flags[6:0], 1'b0};
            n_tokens = r_tokens - TOKEN_W'(1);
            if (emit_done) begin
                n_phase = PH_DONE;
            end else if (r_tokens == TOKEN_W'(1)) begin
                n_phase = PH_FLAGS;
            end else begin
                n_phase = PH_TOKEN;
            end
        end

        if (emit) begin
            n_wc        = wc_inc;
            n_wp        = ptr_inc(r_wp);
            n_prev      = emit_byte;
            n_out_valid = 1'b1;
            n_out_byte  = emit_byte;
            n_out_last  = emit_last;
            n_out_done  = emit_done;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_HEADER;
            r_total     <= '0;
            r_wc        <= '0;
            r_flags     <= '0;
            r_tokens    <= '0;
            r_high      <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_total     <= n_total;
            r_wc        <= n_wc;
            r_flags     <= n_flags;
            r_tokens    <= n_tokens;
            r_high      <= n_high;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_disp     <= n_disp;
        r_rp       <= n_rp;
        r_prev     <= n_prev;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_window[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_window[r_wp] <= emit_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_out_last;
    assign o_stream_done = r_out_done;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_last)
        else $error("stream_done result is not the last of its transfer");

    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COPY |-> r_cnt != '0)
        else $error("copy running with an empty byte count");

    a_count_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FLAGS || r_phase == PH_TOKEN || r_phase == PH_MATCH)
        |-> r_wc < r_total)
        else $error("output count reached the size while tokens remain");

    a_copy_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COPY && slot_free |=> r_wc == $past(r_wc) + SIZE_W'(1))
        else $error("copy cycle did not advance the output count");

endmodule

`default_nettype wire

@@ bench/lz77_decompress_top_tb.sv @@
// Self-checking testbench for the LZ77 type 10 stream decompressor.
`default_nettype none

module lz77_decompress_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzd_pkg::*;

    localparam int unsigned WINDOW_DEPTH = 4096;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam longint unsigned CYCLE_LIMIT = 400_000;

    typedef struct packed {
        bit [7:0] data;
        bit       last;
        bit       done;
    } out_beat_t;

    class lz77_expected_bytes;
        out_beat_t   expected_q[$];
        t_phase      phase;
        bit [23:0]   total_size;
        bit [23:0]   written;
        bit [7:0]    flags;
        bit [3:0]    tokens_left;
        bit [7:0]    match_hi;
        bit [7:0]    window[WINDOW_DEPTH];
        int unsigned errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_HEADER;
            total_size = '0;
            written = '0;
            flags = '0;
            tokens_left = '0;
            match_hi = '0;
            foreach (window[i]) window[i] = 8'h00;
        endfunction

        function bit [7:0] record(bit [7:0] v);
            window[written % WINDOW_DEPTH] = v;
            written = written + 24'd1;
            return v;
        endfunction

        function void finish_token();
            flags = flags << 1;
            tokens_left = tokens_left - 4'd1;
            if (written >= total_size) begin
                phase = PH_DONE;
            end else if (tokens_left == 0) begin
                phase = PH_FLAGS;
            end else begin
                phase = PH_TOKEN;
            end
        endfunction

        function void take_input(bit [7:0] b, bit st);
            bit [7:0]    vals[18];
            int unsigned n;
            bit [12:0]   disp;
            bit [4:0]    len;
            int unsigned src;
            out_beat_t   beat;
            n = 0;
            if (st) restart();
            case (phase)
                PH_HEADER: phase = PH_SIZE0;
                PH_SIZE0: begin
                    total_size = {16'd0, b};
                    phase = PH_SIZE1;
                end
                PH_SIZE1: begin
                    total_size[15:8] = b;
                    phase = PH_SIZE2;
                end
                PH_SIZE2: begin
                    total_size[23:16] = b;
                    phase = (total_size == 0) ? PH_DONE : PH_FLAGS;
                end
                PH_FLAGS: begin
                    flags = b;
                    tokens_left = TOKENS_PER_FLAG;
                    phase = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (flags[7]) begin
                        match_hi = b;
                        phase = PH_MATCH;
                    end else begin
                        vals[n] = record(b);
                        n++;
                        finish_token();
                    end
                end
                PH_MATCH: begin
                    disp = {1'b0, match_hi[3:0], b} + DISP_BIAS;
                    len = {1'b0, match_hi[7:4]} + LEN_BIAS;
                    for (int j = 0; j < len && written < total_size; j++) begin
                        src = (written + WINDOW_DEPTH - disp) % WINDOW_DEPTH;
                        vals[n] = record(window[src]);
                        n++;
                    end
                    finish_token();
                end
                default: ;
            endcase
            for (int unsigned i = 0; i < n; i++) begin
                beat.data = vals[i];
                beat.last = (i == n - 1);
                beat.done = (i == n - 1) && (phase == PH_DONE);
                expected_q.push_back(beat);
            end
        endfunction

        function void check_output(bit [7:0] b, bit last, bit done);
            out_beat_t want;
            if (expected_q.size() == 0) begin
                $error("out_byte: no transfer expected, got 0x%02h", b);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (want.data != b) begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, b);
                errors++;
            end
            if (want.last != last) begin
                $error("run_last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
            if (want.done != done) begin
                $error("stream_done: expected %0d, actual %0d", want.done, done);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_stream_start;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_stream_done;

    lz77_expected_bytes ledger = new();
    int unsigned        burst_left = 0;
    int unsigned        sent_count = 0;
    bit                 hold_go = 1'b0;
    longint unsigned    cycle_count = 0;

    lz77_decompress_top #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_byte(i_in_byte),
        .i_stream_start(i_stream_start),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte(o_out_byte),
        .o_run_last(o_run_last),
        .o_stream_done(o_stream_done)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lz77_decompress_top verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            ledger.check_output(o_out_byte, o_run_last, o_stream_done);
        end
    end

    initial begin : rx_side
        int unsigned run;
        bit          hold_done;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            run = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0: repeat (run) begin
                    i_out_ready <= 1'b1;
                    @(posedge i_clk);
                end
                1: repeat (run) begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                    @(posedge i_clk);
                end
                default: repeat (run) begin
                    i_out_ready <= ($urandom_range(0, 1) != 0);
                    @(posedge i_clk);
                end
            endcase
        end
    end

    task automatic send_item(input bit [7:0] b, input bit st);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_stream_start <= st;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.take_input(b, st);
        sent_count++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    task automatic send_stream(input int unsigned size, input int unsigned cut, input bit big);
        int unsigned produced;
        int unsigned tokens;
        int unsigned len;
        int unsigned disp;
        bit [7:0]    flag;
        bit [11:0]   dcode;
        bit [3:0]    lcode;
        bit          stop;
        produced = 0;
        tokens = 0;
        stop = 1'b0;
        send_item(8'($urandom), 1'b1);
        send_item(size[7:0], 1'b0);
        send_item(size[15:8], 1'b0);
        send_item(size[23:16], 1'b0);
        while (produced < size && !stop) begin
            flag = big ? 8'($urandom | $urandom | $urandom) : 8'($urandom);
            send_item(flag, 1'b0);
            for (int k = 7; k >= 0 && produced < size && !stop; k--) begin
                if (cut != 0 && tokens == cut) stop = 1'b1;
                if (flag[k]) begin
                    len = big ? 18 : $urandom_range(3, 18);
                    if (produced == 0 || $urandom_range(0, 3) == 0) begin
                        disp = $urandom_range(1, 4096);
                    end else begin
                        disp = $urandom_range(1, (produced < 32) ? produced : 32);
                    end
                    lcode = 4'(len - 3);
                    dcode = 12'(disp - 1);
                    send_item({lcode, dcode[11:8]}, 1'b0);
                    if (!stop) send_item(dcode[7:0], 1'b0);
                    produced += len;
                end else if (!stop) begin
                    send_item(8'($urandom), 1'b0);
                    produced++;
                end
                tokens++;
            end
        end
        repeat ($urandom_range(0, 2)) send_item(8'($urandom), 1'b0);
    endtask

    initial begin : stimulus
        int unsigned sel;
        int unsigned mark;
        bit          big_done;
        big_done = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_byte <= 8'h00;
        i_stream_start <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First header arrives without a start marker; the long match copies zeros from
        // before the output start and ends at the declared size; later bytes are ignored.
        send_item(8'h10, 1'b0);
        send_item(8'h05, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hC0, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);

        // Literals around a shortest match at the largest distance.
        send_item(8'hFF, 1'b1);
        send_item(8'h06, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hA5, 1'b0);

        // A zero size completes at once and the following byte is ignored.
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h55, 1'b0);
        drain();

        hold_go = 1'b1;
        mark = sent_count;
        while (sent_count - mark < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (!big_done && sent_count - mark > 30) begin
                big_done = 1'b1;
                send_stream($urandom_range(4100, 4200), 0, 1'b1);
            end else if (sel == 0) begin
                send_stream(0, 0, 1'b0);
            end else if (sel == 1) begin
                send_stream({8'($urandom_range(1, 255)), 16'($urandom)},
                            $urandom_range(1, 20), 1'b0);
            end else if (sel == 2) begin
                send_stream($urandom_range(20, 60), $urandom_range(1, 4), 1'b0);
            end else begin
                send_stream($urandom_range(1, 48), 0, 1'b0);
            end
            if ($urandom_range(0, 7) == 0) drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("lz77_decompress_top verification clean");
        end else begin
            $display("lz77_decompress_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/lzd_pkg.sv
hw/rtl/lz77_decompress_top.sv
bench/lz77_decompress_top_tb.sv
